>>> sv/amx_pkg.sv
`timescale 1ns / 1ps
// amx_pkg: shared types, micro-op codes and helpers for the micro-op execute unit
// depends on nothing

package amx_pkg;

    localparam int MEM_WORDS     = 4096;
    localparam int MEM_AW        = $clog2(MEM_WORDS);
    localparam int TEMP_COUNT    = 8;
    localparam int MAX_BLOCK_OPS = 256;
    localparam int OPCNT_W       = $clog2(MAX_BLOCK_OPS + 1);
    localparam logic [8:0] RETIRE_MAX = 9'd511;

    localparam logic [5:0] K_NOP   = 6'd0;
    localparam logic [5:0] K_MOV   = 6'd1;
    localparam logic [5:0] K_LI    = 6'd2;
    localparam logic [5:0] K_ADD   = 6'd3;
    localparam logic [5:0] K_SUB   = 6'd4;
    localparam logic [5:0] K_RSB   = 6'd5;
    localparam logic [5:0] K_ADC   = 6'd6;
    localparam logic [5:0] K_SBC   = 6'd7;
    localparam logic [5:0] K_RSC   = 6'd8;
    localparam logic [5:0] K_MUL   = 6'd9;
    localparam logic [5:0] K_MLA   = 6'd10;
    localparam logic [5:0] K_AND   = 6'd11;
    localparam logic [5:0] K_ORR   = 6'd12;
    localparam logic [5:0] K_EOR   = 6'd13;
    localparam logic [5:0] K_BIC   = 6'd14;
    localparam logic [5:0] K_MVN   = 6'd15;
    localparam logic [5:0] K_LSL   = 6'd16;
    localparam logic [5:0] K_LSR   = 6'd17;
    localparam logic [5:0] K_ASR   = 6'd18;
    localparam logic [5:0] K_ROR   = 6'd19;
    localparam logic [5:0] K_FNZ   = 6'd20;
    localparam logic [5:0] K_FADD  = 6'd21;
    localparam logic [5:0] K_FSUB  = 6'd22;
    localparam logic [5:0] K_LD32  = 6'd23;
    localparam logic [5:0] K_LD16  = 6'd24;
    localparam logic [5:0] K_LD8   = 6'd25;
    localparam logic [5:0] K_ST32  = 6'd26;
    localparam logic [5:0] K_ST16  = 6'd27;
    localparam logic [5:0] K_ST8   = 6'd28;
    localparam logic [5:0] K_B     = 6'd29;
    localparam logic [5:0] K_BCOND = 6'd30;
    localparam logic [5:0] K_SYNC  = 6'd31;
    localparam logic [5:0] K_FALLBACK = 6'd32;

    localparam logic [4:0] SEL_PC    = 5'd15;
    localparam logic [4:0] SEL_CPSR  = 5'd16;
    localparam logic [4:0] SEL_TMP0  = 5'd17;
    localparam logic [4:0] SEL_CONST = 5'd25;

    localparam logic [2:0] OUT_EXEC  = 3'd0;
    localparam logic [2:0] OUT_SKIP  = 3'd1;
    localparam logic [2:0] OUT_BR    = 3'd2;
    localparam logic [2:0] OUT_FB    = 3'd3;
    localparam logic [2:0] OUT_END   = 3'd4;
    localparam logic [2:0] OUT_IGN   = 3'd5;

    typedef struct packed {
        logic [5:0]  kind;
        logic        dead;
        logic [4:0]  dst;
        logic [4:0]  src1;
        logic [4:0]  src2;
        logic [31:0] imm;
        logic [3:0]  cond;
        logic        no_cond;
        logic [31:0] instr_addr;
        logic        block_start;
        logic        block_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pc_value;
        logic [31:0] status_word;
        logic [31:0] written_value;
        logic [2:0]  outcome;
        logic [8:0]  retired_count;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_PLAIN,
        CLS_LOAD,
        CLS_STORE,
        CLS_BRANCH,
        CLS_EXIT
    } t_op_class;

    typedef struct packed {
        t_in_item  item;
        t_op_class cls;
    } t_q_entry;

    typedef logic [15:0][31:0] t_rf;
    typedef logic [TEMP_COUNT-1:0][31:0] t_tf;

    function automatic logic cond_ok(input logic [31:0] cpsr, input logic [3:0] cc);
        logic n, z, c, v, r;
        n = cpsr[31];
        z = cpsr[30];
        c = cpsr[29];
        v = cpsr[28];
        case (cc)
            4'd0:    r = z;
            4'd1:    r = !z;
            4'd2:    r = c;
            4'd3:    r = !c;
            4'd4:    r = n;
            4'd5:    r = !n;
            4'd6:    r = v;
            4'd7:    r = !v;
            4'd8:    r = c && !z;
            4'd9:    r = !c || z;
            4'd10:   r = (n == v);
            4'd11:   r = (n != v);
            4'd12:   r = !z && (n == v);
            4'd13:   r = z || (n != v);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] bump(input logic [8:0] v);
        return (v == RETIRE_MAX) ? v : v + 9'd1;
    endfunction

endpackage

>>> sv/arm_microop_execute_unit.sv
`timescale 1ns / 1ps
// arm_microop_execute_unit: top level, front queue plus execute back end
// depends on amx_pkg, amx_front, amx_back
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// the back end runs each micro-op as an operand phase (operand read and memory read),
// then an execute phase (execute and state/memory write); it takes no new op until that ends
// the front queue holds 2 transactions and the result register lets the next op start
// while a result waits; a stalled output holds the back end after its operand phase
// synchronous active-low reset clears registers, flags and block state; memory is not cleared

module arm_microop_execute_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  amx_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output amx_pkg::t_out_item o_out_item
);
    import amx_pkg::*;

    logic     w_q_valid, w_q_pop;
    t_q_entry w_q_entry;

    amx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_entry  (w_q_entry)
    );

    amx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_entry   (w_q_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.outcome <= OUT_IGN)
        else $error("outcome code out of range");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.outcome == OUT_IGN |-> o_out_item.written_value == 32'd0)
        else $error("ignored transaction wrote a value");

    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.outcome == OUT_SKIP |-> o_out_item.written_value == 32'd0)
        else $error("skipped transaction wrote a value");

endmodule

>>> sv/amx_front.sv
`timescale 1ns / 1ps
// amx_front: accepts micro-ops, classifies them and queues them for the back end
// depends on amx_pkg

module amx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  amx_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output amx_pkg::t_q_entry o_q_entry
);
    import amx_pkg::*;

    t_q_entry  r_q [2];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op_class w_cls;
    logic      w_push, w_pop;

    always_comb begin
        if (i_in_item.kind == K_LD32 || i_in_item.kind == K_LD16 || i_in_item.kind == K_LD8) begin
            w_cls = CLS_LOAD;
        end else if (i_in_item.kind == K_ST32 || i_in_item.kind == K_ST16 ||
                     i_in_item.kind == K_ST8) begin
            w_cls = CLS_STORE;
        end else if (i_in_item.kind == K_B || i_in_item.kind == K_BCOND) begin
            w_cls = CLS_BRANCH;
        end else if (i_in_item.kind > K_SYNC) begin
            w_cls = CLS_EXIT;
        end else begin
            w_cls = CLS_PLAIN;
        end
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_entry  = r_q[r_rp];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{item: i_in_item, cls: w_cls};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> sv/amx_back.sv
`timescale 1ns / 1ps
// amx_back: two-phase execute stage with architectural state and data memory
// depends on amx_pkg

module amx_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  amx_pkg::t_q_entry  i_q_entry,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output amx_pkg::t_out_item o_out_item
);
    import amx_pkg::*;

    logic [31:0] r_mem [MEM_WORDS];

    t_rf         r_regs, n_regs;
    t_tf         r_tmp, n_tmp;
    logic [31:0] r_cpsr, n_cpsr;
    logic        r_tracked_ok, n_tracked_ok;
    logic [31:0] r_tracked_pc, n_tracked_pc;
    logic        r_skip_ok, n_skip_ok;
    logic [31:0] r_skip_pc, n_skip_pc;
    logic [8:0]  r_retired, n_retired;
    logic        r_thumb, n_thumb;
    logic        r_exited, n_exited;
    logic [OPCNT_W-1:0] r_op_count, n_op_count;

    // operand-phase and result registers
    logic        r_busy;
    t_q_entry    r_op;
    logic [31:0] r_x, r_y, r_k, r_dv, r_ad, r_rdata;
    logic        r_pass;
    logic        r_out_valid;
    t_out_item   r_out;

    // operand phase
    logic        a_thumb;
    logic [31:0] a_pcread, a_x, a_y, a_k, a_dv, a_ad;
    t_tf         a_tmp;
    logic        w_pop, w_done;

    function automatic logic [31:0] opnd(input logic [4:0] sel, input logic [31:0] konst,
                                         input logic [31:0] pcread, input t_rf regs,
                                         input t_tf tmps, input logic [31:0] cpsr);
        logic [4:0]  toff;
        logic [31:0] v;
        toff = sel - SEL_TMP0;
        if (sel < SEL_PC) v = regs[sel[3:0]];
        else if (sel == SEL_PC) v = pcread;
        else if (sel == SEL_CPSR) v = cpsr;
        else if (sel >= SEL_TMP0 && sel < SEL_CONST) v = tmps[toff[2:0]];
        else if (sel == SEL_CONST) v = konst;
        else v = 32'd0;
        return v;
    endfunction

    always_comb begin
        a_thumb  = i_q_entry.item.block_start ? r_cpsr[5] : r_thumb;
        a_tmp    = i_q_entry.item.block_start ? '0 : r_tmp;
        a_pcread = a_thumb ? ((i_q_entry.item.instr_addr + 32'd4) & ~32'd3)
                           : (i_q_entry.item.instr_addr + 32'd8);
        a_x  = opnd(i_q_entry.item.src1, i_q_entry.item.imm, a_pcread, r_regs, a_tmp, r_cpsr);
        a_y  = opnd(i_q_entry.item.src2, i_q_entry.item.imm, a_pcread, r_regs, a_tmp, r_cpsr);
        a_dv = opnd(i_q_entry.item.dst, i_q_entry.item.imm, a_pcread, r_regs, a_tmp, r_cpsr);
        a_k  = (i_q_entry.item.imm <= {27'd0, SEL_CONST})
             ? opnd(i_q_entry.item.imm[4:0], 32'd0, a_pcread, r_regs, a_tmp, r_cpsr) : 32'd0;
        a_ad = a_x + i_q_entry.item.imm;
    end

    assign w_pop   = i_q_valid && !r_busy;
    assign w_done  = r_busy && (!r_out_valid || i_out_ready);
    assign o_q_pop = w_pop;

    // execute phase
    t_in_item    it;
    logic        e_thumb;
    logic [31:0] e_step, res, wv, lane, mask, sub_q;
    logic [32:0] wide;
    logic        put;
    logic [2:0]  oc;
    logic [4:0]  toff;
    logic [4:0]  sh;
    logic        mem_we;
    logic [31:0] mem_wdata;

    always_comb begin
        n_regs = r_regs; n_tmp = r_tmp; n_cpsr = r_cpsr;
        n_tracked_ok = r_tracked_ok; n_tracked_pc = r_tracked_pc;
        n_skip_ok = r_skip_ok; n_skip_pc = r_skip_pc;
        n_retired = r_retired; n_thumb = r_thumb; n_exited = r_exited;
        n_op_count = r_op_count;
        it = r_op.item;
        res = 32'd0; wv = 32'd0; put = 1'b0; oc = OUT_EXEC;
        mem_we = 1'b0; mem_wdata = r_rdata;
        toff = it.dst - SEL_TMP0;
        sh = 5'd0; mask = 32'd0; lane = 32'd0; sub_q = 32'd0; wide = 33'd0;
        e_thumb = it.block_start ? r_cpsr[5] : r_thumb;
        e_step  = e_thumb ? 32'd2 : 32'd4;
        if (it.block_start) begin
            n_tmp = '0; n_retired = 9'd0; n_tracked_ok = 1'b0; n_skip_ok = 1'b0;
            n_exited = 1'b0; n_op_count = '0; n_thumb = e_thumb;
        end
        if (n_exited || n_op_count >= OPCNT_W'(MAX_BLOCK_OPS)) begin
            oc = OUT_IGN;
        end else begin
            n_op_count = n_op_count + 1'b1;
            if (n_skip_ok && it.instr_addr == n_skip_pc) begin
                oc = OUT_SKIP;
            end else begin
                n_skip_ok = 1'b0;
                if (it.dead) begin
                    oc = OUT_EXEC;
                end else if (!it.no_cond && !r_pass) begin
                    n_skip_ok = 1'b1;
                    n_skip_pc = it.instr_addr;
                    n_regs[15] = it.instr_addr + e_step;
                    n_retired = bump(n_retired);
                    oc = OUT_SKIP;
                end else begin
                    if (!n_tracked_ok || it.instr_addr != n_tracked_pc) begin
                        if (n_tracked_ok) n_retired = bump(n_retired);
                        n_tracked_ok = 1'b1;
                        n_tracked_pc = it.instr_addr;
                    end
                    case (it.kind)
                        K_NOP: ;
                        K_MOV, K_SYNC: begin res = r_x; put = 1'b1; end
                        K_LI:  begin res = it.imm; put = 1'b1; end
                        K_ADD: begin res = r_x + r_y; put = 1'b1; end
                        K_SUB: begin res = r_x - r_y; put = 1'b1; end
                        K_RSB: begin res = r_y - r_x; put = 1'b1; end
                        K_ADC: begin res = r_x + r_y + {31'd0, r_cpsr[29]}; put = 1'b1; end
                        K_SBC: begin res = r_x + ~r_y + {31'd0, r_cpsr[29]}; put = 1'b1; end
                        K_RSC: begin res = r_y + ~r_x + {31'd0, r_cpsr[29]}; put = 1'b1; end
                        K_MUL: begin res = r_x * r_y; put = 1'b1; end
                        K_MLA: begin res = r_x * r_y + r_k; put = 1'b1; end
                        K_AND: begin res = r_x & r_y; put = 1'b1; end
                        K_ORR: begin res = r_x | r_y; put = 1'b1; end
                        K_EOR: begin res = r_x ^ r_y; put = 1'b1; end
                        K_BIC: begin res = r_x & ~r_y; put = 1'b1; end
                        K_MVN: begin res = ~r_x; put = 1'b1; end
                        K_LSL: begin
                            res = (r_y < 32'd32) ? (r_x << r_y[4:0]) : 32'd0; put = 1'b1;
                        end
                        K_LSR: begin
                            res = (r_y < 32'd32) ? (r_x >> r_y[4:0]) : 32'd0; put = 1'b1;
                        end
                        K_ASR: begin
                            sh = (r_y > 32'd31) ? 5'd31 : r_y[4:0];
                            res = $unsigned($signed(r_x) >>> sh); put = 1'b1;
                        end
                        K_ROR: begin
                            sh = r_y[4:0];
                            res = (r_x >> sh) | (r_x << (6'd32 - {1'b0, sh})); put = 1'b1;
                        end
                        K_FNZ: begin
                            n_cpsr[31] = r_x[31];
                            n_cpsr[30] = (r_x == 32'd0);
                        end
                        K_FADD, K_FSUB: begin
                            sub_q = (it.kind == K_FSUB) ? ~r_y : r_y;
                            wide = {1'b0, r_x} + {1'b0, sub_q} + {32'd0, it.kind == K_FSUB};
                            n_cpsr[31] = r_dv[31];
                            n_cpsr[30] = (r_dv == 32'd0);
                            n_cpsr[29] = wide[32];
                            n_cpsr[28] = (it.kind == K_FSUB)
                                ? ((r_x[31] ^ r_y[31]) & (r_x[31] ^ r_dv[31]))
                                : (~(r_x[31] ^ r_y[31]) & (r_x[31] ^ r_dv[31]));
                        end
                        K_LD32: begin res = r_rdata; put = 1'b1; end
                        K_LD16: begin
                            res = {16'd0, r_ad[1] ? r_rdata[31:16] : r_rdata[15:0]}; put = 1'b1;
                        end
                        K_LD8: begin
                            lane = r_rdata >> {r_ad[1:0], 3'd0};
                            res = {24'd0, lane[7:0]}; put = 1'b1;
                        end
                        K_ST32, K_ST16, K_ST8: begin
                            if (it.kind == K_ST32) begin
                                sh = 5'd0; mask = 32'hffff_ffff;
                            end else if (it.kind == K_ST16) begin
                                sh = {r_ad[1], 4'd0}; mask = 32'h0000_ffff;
                            end else begin
                                sh = {r_ad[1:0], 3'd0}; mask = 32'h0000_00ff;
                            end
                            wv = r_y & mask;
                            mem_we = (r_op.cls == CLS_STORE);
                            mem_wdata = (r_rdata & ~(mask << sh)) | (wv << sh);
                        end
                        K_B: begin
                            if (it.src1 == SEL_CONST) begin
                                n_regs[15] = it.imm;
                            end else begin
                                n_cpsr[5] = r_x[0];
                                n_regs[15] = {r_x[31:1], 1'b0};
                            end
                            n_retired = bump(n_retired);
                            wv = n_regs[15];
                            oc = OUT_BR;
                        end
                        K_BCOND: begin
                            n_regs[15] = r_pass ? it.imm : it.instr_addr + e_step;
                            n_retired = bump(n_retired);
                            wv = n_regs[15];
                            oc = OUT_BR;
                        end
                        default: begin
                            n_regs[15] = it.instr_addr;
                            oc = OUT_FB;
                        end
                    endcase
                    if (put) begin
                        if (it.dst < SEL_PC) begin
                            n_regs[it.dst[3:0]] = res; wv = res;
                        end else if (it.dst == SEL_PC) begin
                            wv = res & (e_thumb ? ~32'd1 : ~32'd3);
                            n_regs[15] = wv;
                        end else if (it.dst == SEL_CPSR) begin
                            n_cpsr = res; wv = res;
                        end else if (it.dst >= SEL_TMP0 && it.dst < SEL_CONST) begin
                            n_tmp[toff[2:0]] = res; wv = res;
                        end
                    end
                end
            end
            if (oc == OUT_BR || oc == OUT_FB) begin
                n_exited = 1'b1;
            end else if (it.block_end) begin
                if (n_tracked_ok) begin
                    n_retired = bump(n_retired);
                    n_regs[15] = n_tracked_pc + e_step;
                end
                n_exited = 1'b1;
                oc = OUT_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op   <= i_q_entry;
            r_x    <= a_x;
            r_y    <= a_y;
            r_k    <= a_k;
            r_dv   <= a_dv;
            r_ad   <= a_ad;
            r_pass <= cond_ok(r_cpsr, i_q_entry.item.cond);
            if (i_q_entry.cls == CLS_LOAD || i_q_entry.cls == CLS_STORE) begin
                r_rdata <= r_mem[a_ad[MEM_AW+1:2]];
            end
        end
        if (w_done && mem_we) begin
            r_mem[r_ad[MEM_AW+1:2]] <= mem_wdata;
        end
        if (w_done) begin
            r_out <= '{pc_value: n_regs[15], status_word: n_cpsr, written_value: wv,
                       outcome: oc, retired_count: n_retired};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_out_valid <= 1'b0;
            r_regs <= '0; r_tmp <= '0; r_cpsr <= 32'd0;
            r_tracked_ok <= 1'b0; r_tracked_pc <= 32'd0;
            r_skip_ok <= 1'b0; r_skip_pc <= 32'd0;
            r_retired <= 9'd0; r_thumb <= 1'b0; r_exited <= 1'b0; r_op_count <= '0;
        end else begin
            if (w_pop) r_busy <= 1'b1;
            else if (w_done) r_busy <= 1'b0;
            if (w_done) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (w_done) begin
                r_regs <= n_regs; r_tmp <= n_tmp; r_cpsr <= n_cpsr;
                r_tracked_ok <= n_tracked_ok; r_tracked_pc <= n_tracked_pc;
                r_skip_ok <= n_skip_ok; r_skip_pc <= n_skip_pc;
                r_retired <= n_retired; r_thumb <= n_thumb; r_exited <= n_exited;
                r_op_count <= n_op_count;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
